[src/assert_macros.svh]
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HMS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hms assertion failed");

`define HMS_ASSERT_NEVER(name, clk, rst, cond) \
   `HMS_ASSERT(name, clk, rst, !(cond))

`else

`define HMS_ASSERT(name, clk, rst, prop)

`define HMS_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

[src/hms_pkg.sv]
package hms_pkg;

   localparam int LEN_BITS_DEFAULT = 48;
   localparam int LENGTH_VALUE_BITS = 48;
   localparam int HEX_RADIX = 16;

   localparam logic [7:0] CHR_TAB = 8'h09;
   localparam logic [7:0] CHR_LF = 8'h0A;
   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_SEMI = 8'h3B;

   localparam logic [3:0] CLEN_LAST = 4'd15;
   localparam logic [4:0] CHUNKED_LAST = 5'd25;

   localparam logic [1:0] CLASS_HEADER = 2'd0;
   localparam logic [1:0] CLASS_BODY = 2'd1;
   localparam logic [1:0] CLASS_CDATA = 2'd2;
   localparam logic [1:0] CLASS_FRAMING = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_CLEN = 2'd1;
   localparam logic [1:0] KIND_CHUNKED = 2'd2;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_BAD_CLEN = 2'd1;
   localparam logic [1:0] ERR_NO_CRLF = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   typedef enum logic [7:0] {
      PH_HEADER  = 8'b0000_0001,
      PH_BODY    = 8'b0000_0010,
      PH_CSIZE   = 8'b0000_0100,
      PH_CEXT    = 8'b0000_1000,
      PH_CDATA   = 8'b0001_0000,
      PH_CCR     = 8'b0010_0000,
      PH_CLF     = 8'b0100_0000,
      PH_TRAILER = 8'b1000_0000
   } phase_type;

   typedef enum logic [3:0] {
      CLP_SKIP   = 4'b0001,
      CLP_DIGITS = 4'b0010,
      CLP_ENDED  = 4'b0100,
      CLP_FAILED = 4'b1000
   } clen_step_type;

   typedef struct packed {
      logic [7:0]                   out_byte;
      logic [1:0]                   byte_class;
      logic                         header_done;
      logic [1:0]                   body_kind;
      logic [LENGTH_VALUE_BITS-1:0] length_value;
      logic                         size_done;
      logic                         chunk_done;
      logic                         message_done;
      logic [1:0]                   error_code;
   } rsp_fields_type;

   // Header terminator CR LF CR LF
   function automatic logic [7:0] end_char(input logic [1:0] pos);
      return pos[0] ? CHR_LF : CHR_CR;
   endfunction

   function automatic logic [7:0] clen_char(input logic [3:0] pos);
      case (pos)
         4'd0: return "C";
         4'd1: return "o";
         4'd2: return "n";
         4'd3: return "t";
         4'd4: return "e";
         4'd5: return "n";
         4'd6: return "t";
         4'd7: return "-";
         4'd8: return "L";
         4'd9: return "e";
         4'd10: return "n";
         4'd11: return "g";
         4'd12: return "t";
         4'd13: return "h";
         4'd14: return ":";
         4'd15: return " ";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] chunked_char(input logic [4:0] pos);
      case (pos)
         5'd0: return "T";
         5'd1: return "r";
         5'd2: return "a";
         5'd3: return "n";
         5'd4: return "s";
         5'd5: return "f";
         5'd6: return "e";
         5'd7: return "r";
         5'd8: return "-";
         5'd9: return "E";
         5'd10: return "n";
         5'd11: return "c";
         5'd12: return "o";
         5'd13: return "d";
         5'd14: return "i";
         5'd15: return "n";
         5'd16: return "g";
         5'd17: return ":";
         5'd18: return " ";
         5'd19: return "c";
         5'd20: return "h";
         5'd21: return "u";
         5'd22: return "n";
         5'd23: return "k";
         5'd24: return "e";
         5'd25: return "d";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic is_dec(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return is_dec(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
   endfunction

   // Letters carry 1..6 in the low nibble
   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      return is_dec(b) ? b[3:0] : b[3:0] + 4'd9;
   endfunction

   function automatic logic is_size_delim(input logic [7:0] b);
      return (b == CHR_TAB) || (b == CHR_SPACE) || (b == CHR_SEMI) ||
             (b == CHR_CR) || (b == CHR_LF);
   endfunction

endpackage

[src/hms_req_if.sv]
interface hms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

[src/hms_rsp_if.sv]
interface hms_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  byte_class;
   logic        header_done;
   logic [1:0]  body_kind;
   logic [47:0] length_value;
   logic        size_done;
   logic        chunk_done;
   logic        message_done;
   logic [1:0]  error_code;

   modport source (
      output valid, output out_byte, output byte_class, output header_done,
      output body_kind, output length_value, output size_done, output chunk_done,
      output message_done, output error_code, input ready
   );
   modport sink (
      input valid, input out_byte, input byte_class, input header_done,
      input body_kind, input length_value, input size_done, input chunk_done,
      input message_done, input error_code, output ready
   );
endinterface

[src/http_message_splitter.sv]
// HTTP/1.1 message framer: each request transaction carries one stream byte, and each
// response transaction returns that byte tagged as header, fixed-length body, chunk data
// or chunk framing, with header, chunk-size, chunk and message completion flags and an
// error code. One byte is accepted every clock cycle unless rsp_bus.ready back-pressure
// holds both registers full; a byte passes through the input register and then the result
// register, and all matching, decimal/hex length parsing and counting happens in the
// single logic stage between them. req_bus.ready follows rsp_bus.ready in the same cycle
// when both registers are full. Any error returns the framer to header parsing.
`include "assert_macros.svh"

module http_message_splitter import hms_pkg::*; #(
   parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   hms_req_if.sink   req_bus,
   hms_rsp_if.source rsp_bus
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_fields_ff;
   rsp_fields_type step_fields;
   logic           step_en;
   logic           stage_free;

   // Advance the input register whenever the result register can take its transaction
   assign stage_free    = !rsp_valid_ff || rsp_bus.ready;
   assign step_en       = in_valid_ff && stage_free;
   assign req_bus.ready = !in_valid_ff || stage_free;

   assign in_valid_in  = (req_bus.valid && req_bus.ready) || (in_valid_ff && !stage_free);
   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_bus.ready);

   hms_framer #(
      .LEN_BITS(LEN_BITS)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_byte (in_byte_ff),
      .fields    (step_fields)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
      end
      if (step_en) begin
         rsp_fields_ff <= step_fields;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_byte     = rsp_fields_ff.out_byte;
   assign rsp_bus.byte_class   = rsp_fields_ff.byte_class;
   assign rsp_bus.header_done  = rsp_fields_ff.header_done;
   assign rsp_bus.body_kind    = rsp_fields_ff.body_kind;
   assign rsp_bus.length_value = rsp_fields_ff.length_value;
   assign rsp_bus.size_done    = rsp_fields_ff.size_done;
   assign rsp_bus.chunk_done   = rsp_fields_ff.chunk_done;
   assign rsp_bus.message_done = rsp_fields_ff.message_done;
   assign rsp_bus.error_code   = rsp_fields_ff.error_code;

   `HMS_ASSERT(a_step_fills_result, clock, reset, step_en |=> rsp_valid_ff)
   `HMS_ASSERT(a_stall_holds_input, clock, reset, (in_valid_ff && !stage_free) |=> (in_valid_ff && $stable(in_byte_ff)))
   `HMS_ASSERT_NEVER(a_no_accept_when_blocked, clock, reset, req_bus.ready && in_valid_ff && !stage_free)

endmodule

[src/hms_framer.sv]
`include "assert_macros.svh"

module hms_framer import hms_pkg::*; #(
   parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic [7:0]     data_byte,
   output rsp_fields_type fields
);

   phase_type           phase_ff, phase_in;
   logic [1:0]          end_match_ff, end_match_in;
   logic [3:0]          clen_match_ff, clen_match_in;
   logic [4:0]          chunked_match_ff, chunked_match_in;
   logic                clen_seen_ff, clen_seen_in;
   logic                chunked_seen_ff, chunked_seen_in;
   clen_step_type       clen_step_ff, clen_step_in;
   logic [LEN_BITS-1:0] length_accum_ff, length_accum_in;
   logic [LEN_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                line_empty_ff, line_empty_in;

   logic [LEN_BITS+3:0] accum_x;
   logic [LEN_BITS+3:0] dec_next;
   logic                dec_ovf;
   logic                hex_ovf;
   logic [LEN_BITS-1:0] bytes_dec;
   logic                end_hit;

   logic                clear;
   phase_type           clear_phase;
   logic [LEN_BITS-1:0] clear_bytes;

   function automatic logic [LENGTH_VALUE_BITS-1:0] to_len(input logic [LEN_BITS-1:0] v);
      logic [LEN_BITS+LENGTH_VALUE_BITS-1:0] w;
      w = {{LENGTH_VALUE_BITS{1'b0}}, v};
      return w[LENGTH_VALUE_BITS-1:0];
   endfunction

   // accum * 10 + digit; overflow when it no longer fits LEN_BITS
   assign accum_x  = {4'b0, length_accum_ff};
   assign dec_next = (accum_x << 3) + (accum_x << 1) + {{LEN_BITS{1'b0}}, data_byte[3:0]};
   assign dec_ovf  = |dec_next[LEN_BITS+3:LEN_BITS];
   assign hex_ovf  = |length_accum_ff[LEN_BITS-1:LEN_BITS-4];

   assign bytes_dec = bytes_left_ff - {{(LEN_BITS-1){1'b0}}, |bytes_left_ff};
   assign end_hit   = (end_match_ff == 2'd3) && (data_byte == CHR_LF);

   always_comb begin
      phase_in         = phase_ff;
      end_match_in     = end_match_ff;
      clen_match_in    = clen_match_ff;
      chunked_match_in = chunked_match_ff;
      clen_seen_in     = clen_seen_ff;
      chunked_seen_in  = chunked_seen_ff;
      clen_step_in     = clen_step_ff;
      length_accum_in  = length_accum_ff;
      bytes_left_in    = bytes_left_ff;
      line_empty_in    = line_empty_ff;
      clear            = 1'b0;
      clear_phase      = PH_HEADER;
      clear_bytes      = '0;

      fields            = '0;
      fields.out_byte   = data_byte;
      fields.byte_class = CLASS_FRAMING;

      case (phase_ff)
         PH_HEADER: begin
            fields.byte_class = CLASS_HEADER;

            if (data_byte == end_char(end_match_ff)) begin
               end_match_in = end_match_ff + 2'd1;
            end else begin
               end_match_in = (data_byte == CHR_CR) ? 2'd1 : 2'd0;
            end

            if (!clen_seen_ff) begin
               if ((clen_match_ff == CLEN_LAST) && (data_byte == clen_char(CLEN_LAST))) begin
                  clen_seen_in    = 1'b1;
                  clen_step_in    = CLP_SKIP;
                  length_accum_in = '0;
                  clen_match_in   = '0;
               end else if (data_byte == clen_char(clen_match_ff)) begin
                  clen_match_in = clen_match_ff + 4'd1;
               end else begin
                  clen_match_in = (data_byte == clen_char(4'd0)) ? 4'd1 : 4'd0;
               end
            end else begin
               case (clen_step_ff)
                  CLP_SKIP: begin
                     if ((data_byte == CHR_SPACE) || (data_byte == CHR_TAB)) begin
                        clen_step_in = CLP_SKIP;
                     end else if (is_dec(data_byte)) begin
                        length_accum_in = {{(LEN_BITS-4){1'b0}}, data_byte[3:0]};
                        clen_step_in    = CLP_DIGITS;
                     end else begin
                        length_accum_in = '0;
                        clen_step_in    = CLP_FAILED;
                     end
                  end
                  CLP_DIGITS: begin
                     if (!is_dec(data_byte)) begin
                        clen_step_in = CLP_ENDED;
                     end else if (dec_ovf) begin
                        // nonzero accum marks overflow rather than missing digits
                        length_accum_in = {{(LEN_BITS-1){1'b0}}, 1'b1};
                        clen_step_in    = CLP_FAILED;
                     end else begin
                        length_accum_in = dec_next[LEN_BITS-1:0];
                     end
                  end
                  default: clen_step_in = clen_step_ff;
               endcase
            end

            if (!chunked_seen_ff) begin
               if ((chunked_match_ff == CHUNKED_LAST) &&
                   (data_byte == chunked_char(CHUNKED_LAST))) begin
                  chunked_seen_in  = 1'b1;
                  chunked_match_in = '0;
               end else if (data_byte == chunked_char(chunked_match_ff)) begin
                  chunked_match_in = chunked_match_ff + 5'd1;
               end else begin
                  chunked_match_in = (data_byte == chunked_char(5'd0)) ? 5'd1 : 5'd0;
               end
            end

            if (end_hit) begin
               clear = 1'b1;
               if (clen_seen_in) begin
                  if ((clen_step_in == CLP_SKIP) ||
                      ((clen_step_in == CLP_FAILED) && (length_accum_in == '0))) begin
                     fields.error_code = ERR_BAD_CLEN;
                  end else if (clen_step_in == CLP_FAILED) begin
                     fields.error_code = ERR_OVERFLOW;
                  end else begin
                     fields.header_done  = 1'b1;
                     fields.body_kind    = KIND_CLEN;
                     fields.length_value = to_len(length_accum_in);
                     if (length_accum_in == '0) begin
                        fields.message_done = 1'b1;
                     end else begin
                        clear_bytes = length_accum_in;
                        clear_phase = PH_BODY;
                     end
                  end
               end else if (chunked_seen_in) begin
                  fields.header_done = 1'b1;
                  fields.body_kind   = KIND_CHUNKED;
                  clear_phase        = PH_CSIZE;
               end else begin
                  fields.header_done  = 1'b1;
                  fields.body_kind    = KIND_NONE;
                  fields.message_done = 1'b1;
               end
            end
         end

         PH_BODY: begin
            fields.byte_class = CLASS_BODY;
            bytes_left_in     = bytes_dec;
            if (bytes_dec == '0) begin
               fields.message_done = 1'b1;
               clear               = 1'b1;
            end
         end

         PH_CSIZE: begin
            if (is_hex(data_byte)) begin
               if (hex_ovf) begin
                  fields.error_code = ERR_OVERFLOW;
                  clear             = 1'b1;
               end else begin
                  length_accum_in = {length_accum_ff[LEN_BITS-5:0], hex_nibble(data_byte)};
               end
            end else if (is_size_delim(data_byte)) begin
               fields.size_done    = 1'b1;
               fields.length_value = to_len(length_accum_ff);
               bytes_left_in       = length_accum_ff;
               length_accum_in     = '0;
               phase_in            = PH_CEXT;
               if (data_byte == CHR_LF) begin
                  if (length_accum_ff == '0) begin
                     phase_in      = PH_TRAILER;
                     line_empty_in = 1'b1;
                  end else begin
                     phase_in = PH_CDATA;
                  end
               end
            end
         end

         PH_CEXT: begin
            if (data_byte == CHR_LF) begin
               if (bytes_left_ff == '0) begin
                  phase_in      = PH_TRAILER;
                  line_empty_in = 1'b1;
               end else begin
                  phase_in = PH_CDATA;
               end
            end
         end

         PH_CDATA: begin
            fields.byte_class = CLASS_CDATA;
            bytes_left_in     = bytes_dec;
            if (bytes_dec == '0) begin
               phase_in = PH_CCR;
            end
         end

         PH_CCR: begin
            if (data_byte == CHR_CR) begin
               phase_in = PH_CLF;
            end else begin
               fields.error_code = ERR_NO_CRLF;
               clear             = 1'b1;
            end
         end

         PH_CLF: begin
            if (data_byte == CHR_LF) begin
               fields.chunk_done = 1'b1;
               phase_in          = PH_CSIZE;
               length_accum_in   = '0;
            end else begin
               fields.error_code = ERR_NO_CRLF;
               clear             = 1'b1;
            end
         end

         PH_TRAILER: begin
            if (data_byte == CHR_LF) begin
               if (line_empty_ff) begin
                  fields.message_done = 1'b1;
                  clear               = 1'b1;
               end else begin
                  line_empty_in = 1'b1;
               end
            end else if (data_byte != CHR_CR) begin
               line_empty_in = 1'b0;
            end
         end

         default: begin
            clear = 1'b1;
         end
      endcase

      // Return every matcher and counter to its reset value; phase and byte count take clear_phase and clear_bytes
      if (clear) begin
         phase_in         = clear_phase;
         end_match_in     = '0;
         clen_match_in    = '0;
         chunked_match_in = '0;
         clen_seen_in     = 1'b0;
         chunked_seen_in  = 1'b0;
         clen_step_in     = CLP_SKIP;
         length_accum_in  = '0;
         bytes_left_in    = clear_bytes;
         line_empty_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         end_match_ff     <= '0;
         clen_match_ff    <= '0;
         chunked_match_ff <= '0;
         clen_seen_ff     <= 1'b0;
         chunked_seen_ff  <= 1'b0;
         clen_step_ff     <= CLP_SKIP;
         length_accum_ff  <= '0;
         bytes_left_ff    <= '0;
         line_empty_ff    <= 1'b1;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         end_match_ff     <= end_match_in;
         clen_match_ff    <= clen_match_in;
         chunked_match_ff <= chunked_match_in;
         clen_seen_ff     <= clen_seen_in;
         chunked_seen_ff  <= chunked_seen_in;
         clen_step_ff     <= clen_step_in;
         length_accum_ff  <= length_accum_in;
         bytes_left_ff    <= bytes_left_in;
         line_empty_ff    <= line_empty_in;
      end
   end

   `HMS_ASSERT(a_count_phase_nonzero, clock, reset, ((phase_ff == PH_BODY) || (phase_ff == PH_CDATA)) |-> (bytes_left_ff != '0))
   `HMS_ASSERT(a_error_returns_header, clock, reset, (step_en && (fields.error_code != ERR_NONE)) |=> (phase_ff == PH_HEADER))
   `HMS_ASSERT(a_done_returns_header, clock, reset, (step_en && fields.message_done) |=> (phase_ff == PH_HEADER))
   `HMS_ASSERT_NEVER(a_error_without_done, clock, reset, (fields.error_code != ERR_NONE) && (fields.header_done || fields.message_done))

endmodule

[bench/hms_frame_check.sv]
module hms_frame_check import hms_pkg::*; (
   input  logic clock,
   input  logic reset,
   hms_req_if   req_mon,
   hms_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending,
   output int   messages_done,
   output int   chunks_done,
   output int   errors_seen
);

   localparam logic [47:0] LEN_MAX = {LENGTH_VALUE_BITS{1'b1}};
   localparam int CLEN_CHARS = 16;
   localparam int TE_CHARS = 26;
   localparam logic [8*TE_CHARS-1:0] CLEN_TEXT = "Content-Length: ";
   localparam logic [8*TE_CHARS-1:0] TE_TEXT = "Transfer-Encoding: chunked";

   // Framing state of the predicted stream
   phase_type     frame_phase;
   clen_step_type clen_step;
   logic [2:0]    crlf_run;
   logic [4:0]    clen_pos;
   logic [4:0]    te_pos;
   logic          clen_found;
   logic          te_found;
   logic [47:0]   len_acc;
   logic [47:0]   remaining;
   logic          blank_line;

   rsp_fields_type expected_rsp_q[$];
   int fail_total;
   int msg_total;
   int chunk_total;
   int err_total;

   function automatic void clear_state();
      frame_phase = PH_HEADER;
      clen_step = CLP_SKIP;
      crlf_run = '0;
      clen_pos = '0;
      te_pos = '0;
      clen_found = 1'b0;
      te_found = 1'b0;
      len_acc = '0;
      remaining = '0;
      blank_line = 1'b1;
   endfunction

   // Text is right-aligned in the vector; a miss restarts on the first character
   function automatic logic [4:0] match_next(input logic [4:0] pos,
                                             input logic [8*TE_CHARS-1:0] text,
                                             input int len, input logic [7:0] b);
      logic [7:0] first;
      logic [7:0] want;
      int idx;
      first = text[8*(len-1) +: 8];
      idx = len - 1 - int'(pos);
      want = (idx >= 0) ? text[8*idx +: 8] : 8'h00;
      if ((int'(pos) < len) && (b == want)) return pos + 5'd1;
      return (b == first) ? 5'd1 : 5'd0;
   endfunction

   function automatic void end_size_line();
      if (remaining == 0) begin
         frame_phase = PH_TRAILER;
         blank_line = 1'b1;
      end else begin
         frame_phase = PH_CDATA;
      end
   endfunction

   function automatic rsp_fields_type frame_step(input logic [7:0] b);
      rsp_fields_type r;
      logic [47:0] d;
      logic [47:0] parsed;
      logic is_digit;
      int hexv;
      r = '0;
      r.out_byte = b;
      is_digit = (b >= "0") && (b <= "9");
      d = {44'd0, b[3:0]};
      case (frame_phase)
         PH_HEADER: begin
            r.byte_class = CLASS_HEADER;
            if ((crlf_run < 3'd4) && (b == (crlf_run[0] ? CHR_LF : CHR_CR)))
               crlf_run = crlf_run + 3'd1;
            else
               crlf_run = (b == CHR_CR) ? 3'd1 : 3'd0;
            if (!clen_found) begin
               clen_pos = match_next(clen_pos, CLEN_TEXT, CLEN_CHARS, b);
               if (clen_pos >= CLEN_CHARS) begin
                  clen_found = 1'b1;
                  clen_step = CLP_SKIP;
                  len_acc = '0;
                  clen_pos = '0;
               end
            end else begin
               case (clen_step)
                  CLP_SKIP: begin
                     if (is_digit) begin
                        len_acc = d;
                        clen_step = CLP_DIGITS;
                     end else if ((b != CHR_SPACE) && (b != CHR_TAB)) begin
                        len_acc = '0;
                        clen_step = CLP_FAILED;
                     end
                  end
                  CLP_DIGITS: begin
                     if (!is_digit) begin
                        clen_step = CLP_ENDED;
                     end else if (len_acc > (LEN_MAX - d) / 10) begin
                        // nonzero accumulator marks overflow rather than no digits
                        len_acc = 48'd1;
                        clen_step = CLP_FAILED;
                     end else begin
                        len_acc = len_acc * 10 + d;
                     end
                  end
                  default: ;
               endcase
            end
            if (!te_found) begin
               te_pos = match_next(te_pos, TE_TEXT, TE_CHARS, b);
               if (te_pos >= TE_CHARS) begin
                  te_found = 1'b1;
                  te_pos = '0;
               end
            end
            if (crlf_run >= 3'd4) begin
               if (clen_found) begin
                  if ((clen_step == CLP_SKIP) || ((clen_step == CLP_FAILED) && (len_acc == 0))) begin
                     r.error_code = ERR_BAD_CLEN;
                     clear_state();
                  end else if (clen_step == CLP_FAILED) begin
                     r.error_code = ERR_OVERFLOW;
                     clear_state();
                  end else begin
                     parsed = len_acc;
                     clear_state();
                     r.header_done = 1'b1;
                     r.body_kind = KIND_CLEN;
                     r.length_value = parsed;
                     if (parsed == 0) begin
                        r.message_done = 1'b1;
                     end else begin
                        remaining = parsed;
                        frame_phase = PH_BODY;
                     end
                  end
               end else if (te_found) begin
                  clear_state();
                  r.header_done = 1'b1;
                  r.body_kind = KIND_CHUNKED;
                  frame_phase = PH_CSIZE;
               end else begin
                  clear_state();
                  r.header_done = 1'b1;
                  r.body_kind = KIND_NONE;
                  r.message_done = 1'b1;
               end
            end
         end
         PH_BODY: begin
            r.byte_class = CLASS_BODY;
            if (remaining != 0) remaining = remaining - 48'd1;
            if (remaining == 0) begin
               r.message_done = 1'b1;
               clear_state();
            end
         end
         PH_CSIZE: begin
            r.byte_class = CLASS_FRAMING;
            hexv = -1;
            if (is_digit) hexv = int'(b - "0");
            else if ((b >= "a") && (b <= "f")) hexv = int'(b - "a") + 10;
            else if ((b >= "A") && (b <= "F")) hexv = int'(b - "A") + 10;
            if (hexv >= 0) begin
               d = 48'(hexv);
               if (len_acc > ((LEN_MAX - d) >> 4)) begin
                  r.error_code = ERR_OVERFLOW;
                  clear_state();
               end else begin
                  len_acc = (len_acc << 4) + d;
               end
            end else if ((b == CHR_TAB) || (b == CHR_SPACE) || (b == CHR_SEMI) ||
                         (b == CHR_CR) || (b == CHR_LF)) begin
               r.size_done = 1'b1;
               r.length_value = len_acc;
               remaining = len_acc;
               len_acc = '0;
               frame_phase = PH_CEXT;
               if (b == CHR_LF) end_size_line();
            end
         end
         PH_CEXT: begin
            r.byte_class = CLASS_FRAMING;
            if (b == CHR_LF) end_size_line();
         end
         PH_CDATA: begin
            r.byte_class = CLASS_CDATA;
            if (remaining != 0) remaining = remaining - 48'd1;
            if (remaining == 0) frame_phase = PH_CCR;
         end
         PH_CCR: begin
            r.byte_class = CLASS_FRAMING;
            if (b == CHR_CR) begin
               frame_phase = PH_CLF;
            end else begin
               r.error_code = ERR_NO_CRLF;
               clear_state();
            end
         end
         PH_CLF: begin
            r.byte_class = CLASS_FRAMING;
            if (b == CHR_LF) begin
               r.chunk_done = 1'b1;
               frame_phase = PH_CSIZE;
               len_acc = '0;
            end else begin
               r.error_code = ERR_NO_CRLF;
               clear_state();
            end
         end
         default: begin
            // trailer: CR keeps the empty-line flag, LF on an empty line ends it
            r.byte_class = CLASS_FRAMING;
            if (b == CHR_LF) begin
               if (blank_line) begin
                  r.message_done = 1'b1;
                  clear_state();
               end else begin
                  blank_line = 1'b1;
               end
            end else if (b != CHR_CR) begin
               blank_line = 1'b0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic string show_rsp(input rsp_fields_type r);
      return $sformatf("byte %h class %0d hdr %0b kind %0d len %0d size %0b chunk %0b msg %0b err %0d",
                       r.out_byte, r.byte_class, r.header_done, r.body_kind, r.length_value,
                       r.size_done, r.chunk_done, r.message_done, r.error_code);
   endfunction

   always @(posedge clock) begin : track
      rsp_fields_type want;
      rsp_fields_type got;
      if (reset) begin
         clear_state();
         expected_rsp_q.delete();
         fail_total = 0;
         msg_total = 0;
         chunk_total = 0;
         err_total = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            want = frame_step(req_mon.data_byte);
            expected_rsp_q.push_back(want);
            msg_total += int'(want.message_done);
            chunk_total += int'(want.chunk_done);
            if (want.error_code != ERR_NONE) err_total++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.out_byte, rsp_mon.byte_class, rsp_mon.header_done,
                   rsp_mon.body_kind, rsp_mon.length_value, rsp_mon.size_done,
                   rsp_mon.chunk_done, rsp_mon.message_done, rsp_mon.error_code};
            if (expected_rsp_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) $display("unexpected transaction: %s", show_rsp(got));
            end else begin
               want = expected_rsp_q.pop_front();
               if ((got.out_byte !== want.out_byte) || (got.byte_class !== want.byte_class) ||
                   (got.header_done !== want.header_done) ||
                   (got.body_kind !== want.body_kind) ||
                   (got.length_value !== want.length_value) ||
                   (got.size_done !== want.size_done) ||
                   (got.chunk_done !== want.chunk_done) ||
                   (got.message_done !== want.message_done) ||
                   (got.error_code !== want.error_code)) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("mismatch at %0t expected: %s", $realtime, show_rsp(want));
                     $display("mismatch at %0t actual:   %s", $realtime, show_rsp(got));
                  end
               end
            end
         end
      end
      mismatches <= fail_total;
      pending <= expected_rsp_q.size();
      messages_done <= msg_total;
      chunks_done <= chunk_total;
      errors_seen <= err_total;
   end

endmodule

[bench/tb_http_message_splitter.sv]
module tb_http_message_splitter;
   import hms_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 80;
   localparam int RANDOM_BYTES = 1300;

   logic clock = 1'b0;
   logic reset;

   hms_req_if req_bus();
   hms_rsp_if rsp_bus();

   int send_idle_pct;
   int recv_idle_pct;
   logic hold_req;
   logic hold_taken;
   int hold_left;
   int quiet_cycles;
   int bytes_sent;

   int mismatches;
   int pending;
   int messages_done;
   int chunks_done;
   int errors_seen;

   http_message_splitter uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   hms_frame_check frame_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .mismatches(mismatches),
      .pending(pending),
      .messages_done(messages_done),
      .chunks_done(chunks_done),
      .errors_seen(errors_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random back-pressure plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[http_message_splitter] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bytes_sent++;
   endtask

   task automatic put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_crlf();
      put_byte(CHR_CR);
      put_byte(CHR_LF);
   endtask

   task automatic put_line(input string s);
      put_text(s);
      put_crlf();
   endtask

   task automatic put_rand_bytes(input int n);
      repeat (n) put_byte(8'($urandom_range(255)));
   endtask

   task automatic put_printable(input int n);
      repeat (n) put_byte(8'($urandom_range(8'h21, 8'h7e)));
   endtask

   // Header fields that partly match the framing keywords
   task automatic put_random_field();
      case ($urandom_range(4))
         0: put_line("Content-Type: text");
         1: put_line("Transfer-Encoding: gzip");
         2: put_line("Content-Lengt: 9");
         3: put_line("X-Transfer-Encoding: chunk");
         default: begin
            put_printable($urandom_range(1, 10));
            put_crlf();
         end
      endcase
   endtask

   task automatic put_chunk_size(input int size);
      string digits;
      logic [7:0] c;
      int i;
      digits = $sformatf("%0h", size);
      // ignored characters before the digits leave the value alone
      if ($urandom_range(9) == 0) put_byte($urandom_range(1) ? "x" : "G");
      if ($urandom_range(4) == 0) put_byte("0");
      for (i = 0; i < digits.len(); i++) begin
         c = digits[i];
         if ((c >= "a") && $urandom_range(1)) c = c - 8'h20;
         put_byte(c);
      end
      case ($urandom_range(4))
         0: put_byte(CHR_LF);
         1: put_line(";a=1");
         2: put_line(" ");
         3: begin
            put_byte(CHR_TAB);
            put_line(";q");
         end
         default: put_crlf();
      endcase
   endtask

   task automatic put_chunked_header();
      put_line("Transfer-Encoding: chunked");
      put_crlf();
   endtask

   task automatic send_random_message();
      int pick;
      int n;
      int i;
      int len;
      logic [7:0] b;
      pick = $urandom_range(99);
      put_printable($urandom_range(1, 6));
      put_crlf();
      repeat ($urandom_range(2)) put_random_field();
      if (pick < 30) begin
         if ($urandom_range(9) == 0) put_line("Transfer-Encoding: chunked");
         put_text("Content-Length: ");
         repeat ($urandom_range(2)) put_byte($urandom_range(1) ? CHR_SPACE : CHR_TAB);
         len = ($urandom_range(7) == 0) ? $urandom_range(80) : $urandom_range(12);
         put_line($sformatf("%0d", len));
         if ($urandom_range(3) == 0) put_random_field();
         put_crlf();
         put_rand_bytes(len);
      end else if (pick < 85) begin
         put_line("Transfer-Encoding: chunked");
         if ($urandom_range(3) == 0) put_random_field();
         put_crlf();
         n = (pick >= 75) ? $urandom_range(1, 3) : $urandom_range(3);
         for (i = 0; i < n; i++) begin
            len = $urandom_range(1, 16);
            put_chunk_size(len);
            put_rand_bytes(len);
            if ((pick >= 75) && (i == n - 1)) begin
               // break the CR LF after the data
               if ($urandom_range(1)) begin
                  b = 8'($urandom_range(255));
                  put_byte((b == CHR_CR) ? "Y" : b);
               end else begin
                  b = 8'($urandom_range(255));
                  put_byte(CHR_CR);
                  put_byte((b == CHR_LF) ? "Y" : b);
               end
               return;
            end
            put_crlf();
         end
         put_chunk_size(0);
         repeat ($urandom_range(1)) put_random_field();
         put_crlf();
      end else if (pick < 90) begin
         put_crlf();
      end else if (pick < 95) begin
         case ($urandom_range(2))
            0: put_line("Content-Length: ab");
            1: put_line("Content-Length: ");
            default: begin
               put_text("Content-Length: 9");
               repeat ($urandom_range(15, 19)) put_byte(8'($urandom_range("0", "9")));
               put_crlf();
            end
         endcase
         put_crlf();
      end else if (pick < 98) begin
         put_crlf();
         put_line("Transfer-Encoding: chunked");
         put_crlf();
         put_byte("1");
         repeat ($urandom_range(12, 14)) put_byte($urandom_range(1) ? "f" : "0");
         put_crlf();
      end else begin
         put_rand_bytes($urandom_range(1, 10));
         put_crlf();
         put_crlf();
      end
   endtask

   initial begin
      int start_count;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      send_idle_pct = 21;
      recv_idle_pct = 69;
      hold_req = 1'b0;
      bytes_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no body, zero length, blanks before the length and a short body
      put_line("A");
      put_crlf();
      put_line("Content-Length: 0");
      put_crlf();
      put_text("Content-Length: ");
      put_byte(CHR_TAB);
      put_line(" 3");
      put_crlf();
      put_byte(8'h00);
      put_byte(8'hff);
      put_byte(CHR_LF);
      // bad and overflowing content lengths
      put_line("Content-Length: x");
      put_crlf();
      put_line("Content-Length: ");
      put_crlf();
      put_line("Content-Length: 281474976710656");
      put_crlf();

      // hold the receiver while the sender keeps offering
      hold_req <= 1'b1;
      put_line("CContent-Length: 2");
      put_line("Transfer-Encoding: chunked");
      put_crlf();
      put_text("ab");

      // chunk sizes ended by tab, space, semicolon and LF, ignored characters, trailer
      put_chunked_header();
      put_text("1g");
      put_byte(CHR_TAB);
      put_line(";x");
      put_text("Z");
      put_crlf();
      put_byte("B");
      put_byte(CHR_LF);
      put_rand_bytes(11);
      put_crlf();
      put_line("2 ");
      put_text("qq");
      put_crlf();
      put_line("0;");
      put_line("K: v");
      put_byte(CHR_CR);
      put_crlf();
      // size field without digits
      put_chunked_header();
      put_crlf();
      put_crlf();
      // missing CR, then missing LF after data
      put_chunked_header();
      put_line("2");
      put_text("abX");
      put_chunked_header();
      put_line("1");
      put_text("q");
      put_byte(CHR_CR);
      put_text("Z");
      // hex size overflow
      put_chunked_header();
      put_text("1000000000000");
      put_crlf();

      // drain the pipeline before the random section
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         if (bytes_sent - start_count < RANDOM_BYTES / 3) begin
            send_idle_pct = 21;
            recv_idle_pct = 69;
         end else if (bytes_sent - start_count < 2 * RANDOM_BYTES / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random_message();
      end

      // largest chunk size leaves the framer in chunk data for good
      put_printable(2);
      put_crlf();
      put_chunked_header();
      put_text("FFFFFFffffff");
      put_crlf();
      put_rand_bytes(12);
      req_bus.valid <= 1'b0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("framed %0d bytes: %0d messages completed, %0d chunks closed, %0d errors flagged",
               bytes_sent, messages_done, chunks_done, errors_seen);
      $display("included a long receiver hold-off, a full drain and three idle mixes");
      if ((mismatches == 0) && (pending == 0)) begin
         $display("[http_message_splitter] OK");
      end else begin
         $display("[http_message_splitter] ERROR");
      end
      $finish;
   end

endmodule
